### rtl/core/msic_pkg.sv
// Package for the marching-squares isoline cell block.
// Holds the queued cell type, the back-end state type, and the edge plan table.
// Depends on nothing.
package msic_pkg;

  localparam int unsigned GRID_WIDTH_DEF = 1024;
  localparam int unsigned VERTEX_BITS_DEF = 20;
  localparam int unsigned WEIGHT_FRAC_BITS_DEF = 12;

  localparam logic [8:0] ISO_RESET = 9'd128;
  localparam logic LERP_RESET = 1'b1;

  // Register indexes on the configuration port.
  localparam logic REG_ISO = 1'b0;
  localparam logic REG_LERP = 1'b1;

  // Edge codes.
  localparam logic [1:0] EDGE_BOTTOM = 2'd0;
  localparam logic [1:0] EDGE_RIGHT = 2'd1;
  localparam logic [1:0] EDGE_TOP = 2'd2;
  localparam logic [1:0] EDGE_LEFT = 2'd3;

  // Ordered list of crossed edges for one cell.
  typedef struct packed {
    logic [2:0] cnt;
    logic [3:0][1:0] edges;
  } edge_plan_t;

  // One classified cell as it waits between front and back.
  typedef struct packed {
    logic [7:0] sa;
    logic [7:0] sb;
    logic [7:0] sc;
    logic [7:0] sd;
    logic [9:0] x;
    logic [9:0] y;
    logic [9:0] z;
    edge_plan_t plan;
  } cell_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_EDGE, S_DIV, S_CALC, S_FORM, S_OUT, S_DONE
  } back_state_t;

  // Crossed edges in emission order; saddles list both segments in turn.
  function automatic edge_plan_t edge_plan(input logic [3:0] c);
    edge_plan_t p;
    p.cnt = 3'd2;
    p.edges = '{EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM};
    case (c)
      4'd1, 4'd14: begin p.edges[0] = EDGE_BOTTOM; p.edges[1] = EDGE_LEFT; end
      4'd2, 4'd13: begin p.edges[0] = EDGE_BOTTOM; p.edges[1] = EDGE_RIGHT; end
      4'd3, 4'd12: begin p.edges[0] = EDGE_RIGHT; p.edges[1] = EDGE_LEFT; end
      4'd4, 4'd11: begin p.edges[0] = EDGE_RIGHT; p.edges[1] = EDGE_TOP; end
      4'd6, 4'd9: begin p.edges[0] = EDGE_BOTTOM; p.edges[1] = EDGE_TOP; end
      4'd7, 4'd8: begin p.edges[0] = EDGE_TOP; p.edges[1] = EDGE_LEFT; end
      4'd5: begin
        p.cnt = 3'd4;
        p.edges[0] = EDGE_BOTTOM; p.edges[1] = EDGE_RIGHT;
        p.edges[2] = EDGE_TOP; p.edges[3] = EDGE_LEFT;
      end
      4'd10: begin
        p.cnt = 3'd4;
        p.edges[0] = EDGE_RIGHT; p.edges[1] = EDGE_TOP;
        p.edges[2] = EDGE_BOTTOM; p.edges[3] = EDGE_LEFT;
      end
      default: p.cnt = 3'd0;
    endcase
    return p;
  endfunction

endpackage

### rtl/core/msic_cell_if.sv
// Input channel: one grid cell per word.
// Depends on nothing.
interface msic_cell_if;
  logic valid;
  logic ready;
  logic [7:0] corner_a;
  logic [7:0] corner_b;
  logic [7:0] corner_c;
  logic [7:0] corner_d;
  logic [9:0] cell_x;
  logic [9:0] cell_y;
  logic [9:0] slice;
  modport source (output valid, corner_a, corner_b, corner_c, corner_d, cell_x, cell_y,
                  slice, input ready);
  modport sink (input valid, corner_a, corner_b, corner_c, corner_d, cell_x, cell_y,
                slice, output ready);
endinterface

### rtl/core/msic_vtx_if.sv
// Output channel: one edge vertex reference per word.
// Depends on nothing.
interface msic_vtx_if;
  logic valid;
  logic ready;
  logic [19:0] vertex_index;
  logic new_vertex;
  logic [21:0] pos_x;
  logic [21:0] pos_y;
  logic [9:0] pos_z;
  logic [19:0] edge_scalar;
  logic last_of_cell;
  logic overflow;
  modport source (output valid, vertex_index, new_vertex, pos_x, pos_y, pos_z, edge_scalar,
                  last_of_cell, overflow, input ready);
  modport sink (input valid, vertex_index, new_vertex, pos_x, pos_y, pos_z, edge_scalar,
                last_of_cell, overflow, output ready);
endinterface

### rtl/core/msic_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module msic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/msic_front.sv
// Front end: thresholds the corners, builds the edge plan, and queues cells.
// Depends on msic_pkg and msic_cell_if.
module msic_front (
  input  logic clk,
  input  logic rst,
  msic_cell_if.sink cell_in,
  input  logic [8:0] iso_value,
  input  logic hold,
  output logic q_valid,
  output msic_pkg::cell_t q_cell,
  input  logic q_pop
);
  import msic_pkg::*;

  cell_t slot [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic [3:0] case_bits;
  cell_t incoming;
  logic push;

  // Corner classification.
  always_comb begin
    case_bits[0] = {1'b0, cell_in.corner_a} >= iso_value;
    case_bits[1] = {1'b0, cell_in.corner_b} >= iso_value;
    case_bits[2] = {1'b0, cell_in.corner_c} >= iso_value;
    case_bits[3] = {1'b0, cell_in.corner_d} >= iso_value;
    incoming.sa = cell_in.corner_a;
    incoming.sb = cell_in.corner_b;
    incoming.sc = cell_in.corner_c;
    incoming.sd = cell_in.corner_d;
    incoming.x = cell_in.cell_x;
    incoming.y = cell_in.cell_y;
    incoming.z = cell_in.slice;
    incoming.plan = edge_plan(case_bits);
  end

  assign cell_in.ready = (fill != 2'd2) && !hold;
  assign push = cell_in.valid && cell_in.ready;
  assign q_valid = fill != 2'd0;
  assign q_cell = slot[rd_ptr];

  // Two-entry queue between the front and back.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= incoming;
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end
endmodule

### rtl/core/msic_back.sv
// Back end: resolves vertex reuse, divides out edge weights, emits one vertex per edge.
// Depends on msic_pkg, msic_vtx_if and msic_ram.
module msic_back #(
  parameter int unsigned GRID_WIDTH = msic_pkg::GRID_WIDTH_DEF,
  parameter int unsigned VERTEX_BITS = msic_pkg::VERTEX_BITS_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = msic_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic use_lerp,
  input  logic q_valid,
  input  msic_pkg::cell_t q_cell,
  output logic q_pop,
  output logic clearing,
  msic_vtx_if.source vtx_out
);
  import msic_pkg::*;

  localparam int unsigned AW = $clog2(GRID_WIDTH);
  localparam int unsigned VB = VERTEX_BITS;
  localparam int unsigned F = WEIGHT_FRAC_BITS;
  localparam int unsigned DCW = $clog2(F);
  localparam logic [F:0] ONE_W = (F+1)'(1) << F;
  localparam logic [F:0] HALF_W = (F+1)'(1) << (F - 1);

  back_state_t state, state_next;
  cell_t job;
  logic [AW:0] clr;
  logic [VB:0] row_ent;
  logic [VB:0] ram_rdata;
  logic [1:0] ptr;
  logic left_v, nleft_v, ntop_v;
  logic [VB-1:0] left_idx, nleft_idx, ntop_idx;
  logic [VB:0] count;
  logic [F:0] w;
  logic [8:0] rem, den;
  logic [DCW-1:0] div_cnt;
  logic [7:0] sa, sb;
  logic [F+8:0] prod_a, prod_b;
  logic [31:0] px, py;
  logic [VB-1:0] r_index;
  logic r_new, r_ovf;
  logic [21:0] r_px, r_py;
  logic [9:0] r_pz;
  logic [19:0] r_scalar;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VB:0] ram_wdata;
  logic [1:0] cur_edge;
  logic in_row, reuse_left, reuse_row, is_last;
  logic [7:0] e_sa, e_sb;
  logic [8:0] e_den;
  logic [9:0] rem2;
  logic div_bit;
  logic [F:0] off;
  logic [31:0] xs, ys;
  logic [VB:0] count_inc;

  msic_ram #(.WIDTH(VB + 1), .DEPTH(GRID_WIDTH)) u_row_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Per-edge selection and reuse decisions.
  always_comb begin
    cur_edge = job.plan.edges[ptr];
    in_row = 32'(job.x) < GRID_WIDTH;
    reuse_left = (cur_edge == EDGE_LEFT) && (job.x != 10'd0) && left_v;
    reuse_row = (cur_edge == EDGE_BOTTOM) && (job.y != 10'd0) && in_row && row_ent[VB];
    is_last = {1'b0, ptr} == (job.plan.cnt - 3'd1);
    case (cur_edge)
      EDGE_BOTTOM: begin e_sa = job.sa; e_sb = job.sb; end
      EDGE_RIGHT: begin e_sa = job.sb; e_sb = job.sc; end
      EDGE_TOP: begin e_sa = job.sd; e_sb = job.sc; end
      default: begin e_sa = job.sa; e_sb = job.sd; end
    endcase
    e_den = {1'b0, e_sa} + {1'b0, e_sb};
    rem2 = {rem, 1'b0};
    div_bit = rem2 >= {1'b0, den};
    off = use_lerp ? w : HALF_W;
    xs = 32'(job.x) << F;
    ys = 32'(job.y) << F;
    count_inc = count + (VB+1)'(1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr == (AW+1)'(GRID_WIDTH - 1)) state_next = S_IDLE;
      S_IDLE: if (q_valid) state_next = S_LOOK;
      S_LOOK: state_next = (job.plan.cnt == 3'd0) ? S_DONE : S_EDGE;
      S_EDGE: begin
        if (reuse_left || reuse_row || count[VB]) begin
          state_next = S_OUT;
        end else if (e_den == 9'd0) begin
          state_next = S_CALC;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: if (div_cnt == DCW'(F - 1)) state_next = S_CALC;
      S_CALC: state_next = S_FORM;
      S_FORM: state_next = S_OUT;
      S_OUT: if (vtx_out.ready) state_next = is_last ? S_DONE : S_EDGE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory, queue and channel controls.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = AW'(job.x);
    ram_wdata = {ntop_v, ntop_idx};
    ram_raddr = AW'(q_cell.x);
    q_pop = 1'b0;
    clearing = 1'b0;
    vtx_out.valid = 1'b0;
    case (state)
      S_CLEAR: begin
        clearing = 1'b1;
        ram_we = 1'b1;
        ram_waddr = clr[AW-1:0];
        ram_wdata = '0;
      end
      S_IDLE: q_pop = q_valid;
      S_OUT: vtx_out.valid = 1'b1;
      S_DONE: ram_we = in_row;
      default: ram_we = 1'b0;
    endcase
  end

  assign vtx_out.vertex_index = 20'(r_index);
  assign vtx_out.new_vertex = r_new;
  assign vtx_out.pos_x = r_px;
  assign vtx_out.pos_y = r_py;
  assign vtx_out.pos_z = r_pz;
  assign vtx_out.edge_scalar = r_scalar;
  assign vtx_out.last_of_cell = is_last;
  assign vtx_out.overflow = r_ovf;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      left_v <= 1'b0;
      left_idx <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + (AW+1)'(1);
      if (state == S_FORM) count <= count_inc;
      if (state == S_DONE) begin
        left_v <= nleft_v;
        left_idx <= nleft_idx;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: job <= q_cell;
      S_LOOK: begin
        row_ent <= ram_rdata;
        ptr <= 2'd0;
        nleft_v <= 1'b0;
        nleft_idx <= '0;
        ntop_v <= 1'b0;
        ntop_idx <= '0;
      end
      S_EDGE: begin
        sa <= e_sa;
        sb <= e_sb;
        den <= e_den;
        div_cnt <= '0;
        r_new <= 1'b0;
        r_px <= '0;
        r_py <= '0;
        r_pz <= '0;
        r_scalar <= '0;
        r_ovf <= count[VB];
        if (reuse_left || reuse_row) begin
          r_index <= reuse_left ? left_idx : row_ent[VB-1:0];
          if (cur_edge == EDGE_RIGHT) begin
            nleft_v <= 1'b1;
            nleft_idx <= left_idx;
          end
          if (cur_edge == EDGE_TOP) begin
            ntop_v <= 1'b1;
            ntop_idx <= reuse_left ? left_idx : row_ent[VB-1:0];
          end
        end else begin
          r_index <= '1;
        end
        if (e_den == 9'd0) begin
          w <= HALF_W;
        end else if ({1'b0, e_sa} >= e_den) begin
          w <= (F+1)'(1);
          rem <= {1'b0, e_sa} - e_den;
        end else begin
          w <= '0;
          rem <= {1'b0, e_sa};
        end
      end
      S_DIV: begin
        w <= {w[F-1:0], div_bit};
        rem <= div_bit ? 9'(rem2 - {1'b0, den}) : rem2[8:0];
        div_cnt <= div_cnt + DCW'(1);
      end
      S_CALC: begin
        prod_a <= (F+9)'(w) * (F+9)'(sa);
        prod_b <= (F+9)'(ONE_W - w) * (F+9)'(sb);
        case (cur_edge)
          EDGE_BOTTOM: begin px <= xs + 32'(off); py <= ys; end
          EDGE_RIGHT: begin px <= xs + 32'(ONE_W); py <= ys + 32'(off); end
          EDGE_TOP: begin px <= xs + 32'(off); py <= ys + 32'(ONE_W); end
          default: begin px <= xs; py <= ys + 32'(off); end
        endcase
      end
      S_FORM: begin
        r_index <= count[VB-1:0];
        r_new <= 1'b1;
        r_px <= px[21:0];
        r_py <= py[21:0];
        r_pz <= job.z;
        r_scalar <= 20'(32'(prod_a) + 32'(prod_b));
        r_ovf <= count_inc[VB];
        if (cur_edge == EDGE_RIGHT) begin
          nleft_v <= 1'b1;
          nleft_idx <= count[VB-1:0];
        end
        if (cur_edge == EDGE_TOP) begin
          ntop_v <= 1'b1;
          ntop_idx <= count[VB-1:0];
        end
      end
      S_OUT: if (vtx_out.ready) ptr <= ptr + 2'd1;
      default: ;
    endcase
  end
endmodule

### rtl/core/marching_squares_isoline_cells.sv
// Marching-squares isoline cells. A cell passes through lookup and store update and, per
// crossed edge, emits a reused or saturated vertex directly or forms a new one through the
// weight divider, which retires one quotient bit per cycle. Up to two cells wait in a queue.
// Reset is synchronous; after reset the row buffer is cleared, during which no cell is taken.
// Configuration writes are taken at any time.
module marching_squares_isoline_cells #(
  parameter int unsigned GRID_WIDTH = msic_pkg::GRID_WIDTH_DEF,
  parameter int unsigned VERTEX_BITS = msic_pkg::VERTEX_BITS_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = msic_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  msic_cell_if.sink cell_in,
  msic_vtx_if.source vtx_out
);
  import msic_pkg::*;

  logic [8:0] iso_value;
  logic use_lerp;
  logic q_valid, q_pop, clearing;
  cell_t q_cell;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      iso_value <= ISO_RESET;
      use_lerp <= LERP_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_ISO) iso_value <= pwdata[8:0];
      else use_lerp <= pwdata[0];
    end
  end

  // Register read-back.
  always_comb begin
    if (paddr[2] == REG_LERP) prdata = {31'd0, use_lerp};
    else prdata = {23'd0, iso_value};
  end

  msic_front u_front (
    .clk(clk), .rst(rst), .cell_in(cell_in), .iso_value(iso_value), .hold(clearing),
    .q_valid(q_valid), .q_cell(q_cell), .q_pop(q_pop)
  );

  msic_back #(
    .GRID_WIDTH(GRID_WIDTH), .VERTEX_BITS(VERTEX_BITS),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .use_lerp(use_lerp), .q_valid(q_valid), .q_cell(q_cell),
    .q_pop(q_pop), .clearing(clearing), .vtx_out(vtx_out)
  );
endmodule

### tb/sv/marching_squares_isoline_cells_tb.sv
// Testbench for the marching-squares isoline cell block: directed cells, raster grids,
// random noise, stalls and register sweeps, checked against a built-in vertex predictor.
// Depends on msic_pkg, msic_cell_if, msic_vtx_if and marching_squares_isoline_cells.
module marching_squares_isoline_cells_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msic_pkg::*;

  localparam int unsigned FRAC = 12;
  localparam int unsigned ONE_W = 1 << FRAC;
  localparam int unsigned HALF_W = 1 << (FRAC - 1);
  localparam int unsigned COUNT_FULL = 1 << 20;
  localparam int unsigned ROWS = 1024;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 30;

  typedef struct {
    logic [7:0] a, b, c, d;
    logic [9:0] x, y, z;
  } cell_word_t;

  typedef struct {
    logic [19:0] vertex_index;
    logic new_vertex;
    logic [21:0] pos_x;
    logic [21:0] pos_y;
    logic [9:0] pos_z;
    logic [19:0] edge_scalar;
    logic last_of_cell;
    logic overflow;
  } vertex_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  msic_cell_if cell_if();
  msic_vtx_if vtx_if();

  marching_squares_isoline_cells i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cell_in(cell_if), .vtx_out(vtx_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: registers, line buffer, left neighbour slot and vertex counter.
  logic [8:0] iso_reg = ISO_RESET;
  logic lerp_reg = LERP_RESET;
  bit row_ok [ROWS];
  logic [19:0] row_ix [ROWS];
  bit left_ok;
  logic [19:0] left_ix;
  int unsigned vtx_count;

  vertex_word_t pending_vertices[$];
  int errors = 0;
  int cells_taken = 0, words_seen = 0, new_seen = 0;
  bit idle_en = 1'b0;
  int hold_left = 0;

  function automatic int unsigned edge_weight(int unsigned sa, int unsigned sb);
    if (sa + sb == 0) return HALF_W;
    return (sa << FRAC) / (sa + sb);
  endfunction

  // Segment masks of a corner case; saddles give two.
  function automatic int seg_masks(logic [3:0] cs, output logic [3:0] m0,
                                   output logic [3:0] m1);
    m0 = 4'd0;
    m1 = 4'd0;
    case (cs)
      4'd1, 4'd14: m0 = 4'b1001;
      4'd2, 4'd13: m0 = 4'b0011;
      4'd3, 4'd12: m0 = 4'b1010;
      4'd4, 4'd11: m0 = 4'b0110;
      4'd6, 4'd9: m0 = 4'b0101;
      4'd7, 4'd8: m0 = 4'b1100;
      4'd5: begin m0 = 4'b0011; m1 = 4'b1100; end
      4'd10: begin m0 = 4'b0110; m1 = 4'b1001; end
      default: return 0;
    endcase
    return (cs == 4'd5 || cs == 4'd10) ? 2 : 1;
  endfunction

  // Works out the vertex words of one accepted cell and updates the predictor state.
  task automatic predict_cell(input cell_word_t cw);
    int unsigned s[4];
    int unsigned w[4];
    int unsigned sa, sb, off, px, py, xv, yv;
    logic [3:0] cs, m[2];
    int nm, produced;
    bit got_ok, nl_ok, nt_ok;
    logic [19:0] got_ix, nl_ix, nt_ix;
    vertex_word_t r;
    s[0] = 32'(cw.a); s[1] = 32'(cw.b); s[2] = 32'(cw.c); s[3] = 32'(cw.d);
    xv = 32'(cw.x); yv = 32'(cw.y);
    produced = 0;
    nl_ok = 0; nl_ix = '0; nt_ok = 0; nt_ix = '0;
    for (int i = 0; i < 4; i++) cs[i] = (s[i] >= iso_reg);
    w[0] = edge_weight(s[0], s[1]);
    w[1] = edge_weight(s[1], s[2]);
    w[2] = edge_weight(s[3], s[2]);
    w[3] = edge_weight(s[0], s[3]);
    nm = seg_masks(cs, m[0], m[1]);
    for (int k = 0; k < nm; k++) begin
      for (int i = 0; i < 4; i++) begin
        if (!m[k][i]) continue;
        r = '{default: '0};
        got_ok = 0;
        got_ix = '0;
        if (i == EDGE_LEFT && xv != 0 && left_ok) begin
          got_ok = 1; got_ix = left_ix;
        end else if (i == EDGE_BOTTOM && yv != 0 && row_ok[xv]) begin
          got_ok = 1; got_ix = row_ix[xv];
        end
        if (got_ok) begin
          r.vertex_index = got_ix;
        end else if (vtx_count >= COUNT_FULL) begin
          r.vertex_index = 20'(COUNT_FULL - 1);
        end else begin
          off = lerp_reg ? w[i] : HALF_W;
          got_ok = 1;
          got_ix = 20'(vtx_count);
          vtx_count++;
          r.vertex_index = got_ix;
          r.new_vertex = 1'b1;
          case (i)
            EDGE_BOTTOM: begin
              px = (xv << FRAC) + off; py = yv << FRAC; sa = s[0]; sb = s[1];
            end
            EDGE_RIGHT: begin
              px = (xv + 1) << FRAC; py = (yv << FRAC) + off; sa = s[1]; sb = s[2];
            end
            EDGE_TOP: begin
              px = (xv << FRAC) + off; py = (yv + 1) << FRAC; sa = s[3]; sb = s[2];
            end
            default: begin
              px = xv << FRAC; py = (yv << FRAC) + off; sa = s[0]; sb = s[3];
            end
          endcase
          r.pos_x = px[21:0];
          r.pos_y = py[21:0];
          r.pos_z = cw.z;
          r.edge_scalar = 20'(w[i] * sa + (ONE_W - w[i]) * sb);
        end
        r.overflow = (vtx_count >= COUNT_FULL);
        if (i == EDGE_RIGHT) begin nl_ok = got_ok; nl_ix = got_ix; end
        if (i == EDGE_TOP) begin nt_ok = got_ok; nt_ix = got_ix; end
        pending_vertices.push_back(r);
        produced++;
      end
    end
    if (produced > 0) pending_vertices[pending_vertices.size() - 1].last_of_cell = 1'b1;
    left_ok = nl_ok;
    left_ix = nl_ix;
    row_ok[xv] = nt_ok;
    row_ix[xv] = nt_ix;
  endtask

  // Sends one cell word, with an optional idle burst first, and predicts it on acceptance.
  task automatic send_cell(input cell_word_t cw);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 2) == 0) begin
      cell_if.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    cell_if.valid = 1'b1;
    cell_if.corner_a = cw.a;
    cell_if.corner_b = cw.b;
    cell_if.corner_c = cw.c;
    cell_if.corner_d = cw.d;
    cell_if.cell_x = cw.x;
    cell_if.cell_y = cw.y;
    cell_if.slice = cw.z;
    do @(posedge clk); while (!cell_if.ready);
    cells_taken++;
    predict_cell(cw);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    cell_if.valid = 1'b0;
  endtask

  // Waits until every predicted vertex word has come, then lets a cell with no crossing finish.
  task automatic drain();
    stop_sending();
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle; pready is always high.
  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {reg_idx, 2'b00}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (reg_idx == REG_ISO) iso_reg = value[8:0];
    else lerp_reg = value[0];
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_regs(input logic [8:0] iso, input logic lerp);
    drain();
    write_reg(REG_ISO, 32'(iso));
    write_reg(REG_LERP, 32'(lerp));
  endtask

  function automatic cell_word_t random_cell();
    cell_word_t cw;
    cw.a = 8'($urandom); cw.b = 8'($urandom); cw.c = 8'($urandom); cw.d = 8'($urandom);
    cw.x = 10'($urandom_range(0, 1022));
    cw.y = 10'($urandom_range(0, 1022));
    cw.z = 10'($urandom_range(0, 1023));
    return cw;
  endfunction

  // Every corner case with inside and outside samples, then field extremes.
  task automatic test_directed();
    cell_word_t cw;
    for (int cs = 0; cs < 16; cs++) begin
      cw.a = cs[0] ? 8'd200 : 8'd50;
      cw.b = cs[1] ? 8'd230 : 8'd10;
      cw.c = cs[2] ? 8'd255 : 8'd0;
      cw.d = cs[3] ? 8'd128 : 8'd127;
      cw.x = 10'(cs);
      cw.y = 10'd0;
      cw.z = 10'(cs);
      send_cell(cw);
    end
    send_cell('{8'd255, 8'd0, 8'd255, 8'd0, 10'd1022, 10'd1022, 10'd1023});
    send_cell('{8'd0, 8'd255, 8'd0, 8'd255, 10'd1021, 10'd1022, 10'd0});
    send_cell('{8'd0, 8'd255, 8'd255, 8'd0, 10'd0, 10'd1022, 10'd682});
    send_cell('{8'd255, 8'd0, 8'd0, 8'd255, 10'd1022, 10'd1, 10'd341});
  endtask

  // Well-formed raster grids, each from one sample field shared by its cells, so neighbours reuse vertices.
  task automatic test_raster_grids(input int grids);
    logic [7:0] g [0:7][0:5];
    int gw, gh, x0, y0;
    logic [9:0] z;
    for (int n = 0; n < grids; n++) begin
      gw = $urandom_range(2, 6);
      gh = $urandom_range(2, 4);
      x0 = ($urandom_range(0, 3) == 0) ? 1022 - gw + 1 : 0;
      y0 = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1000) : 0;
      z = 10'($urandom);
      for (int i = 0; i <= gw; i++)
        for (int j = 0; j <= gh; j++)
          g[i][j] = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 1) * 255) : 8'($urandom);
      for (int j = 0; j < gh; j++)
        for (int i = 0; i < gw; i++)
          send_cell('{g[i][j], g[i + 1][j], g[i + 1][j + 1], g[i][j + 1],
                      10'(x0 + i), 10'(y0 + j), z});
    end
  endtask

  task automatic test_noise(input int count);
    repeat (count) send_cell(random_cell());
  endtask

  // The receiver holds off for a long stretch while cells keep coming, filling the queue.
  task automatic test_output_stall();
    @(posedge clk);
    hold_left = 300;
    for (int i = 0; i < 10; i++)
      send_cell('{8'd255, 8'd0, 8'd255, 8'd0, 10'(i), 10'd5, 10'd7});
  endtask

  // Receiver: random stall bursts, plus a long hold when a test asks for one.
  int burst_left = 0;
  initial vtx_if.ready = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      vtx_if.ready <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left <= burst_left - 1;
      vtx_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      burst_left <= $urandom_range(0, 3);
      vtx_if.ready <= 1'b0;
    end else begin
      vtx_if.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  // Checks each vertex word against the oldest prediction.
  always @(posedge clk) begin
    vertex_word_t e;
    if (!rst && vtx_if.valid && vtx_if.ready) begin
      words_seen++;
      if (pending_vertices.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex word, index %0d", $realtime, vtx_if.vertex_index);
      end else begin
        e = pending_vertices.pop_front();
        if (e.new_vertex) new_seen++;
        check_field("vertex_index", 32'(e.vertex_index), 32'(vtx_if.vertex_index));
        check_field("new_vertex", 32'(e.new_vertex), 32'(vtx_if.new_vertex));
        check_field("pos_x", 32'(e.pos_x), 32'(vtx_if.pos_x));
        check_field("pos_y", 32'(e.pos_y), 32'(vtx_if.pos_y));
        check_field("pos_z", 32'(e.pos_z), 32'(vtx_if.pos_z));
        check_field("edge_scalar", 32'(e.edge_scalar), 32'(vtx_if.edge_scalar));
        check_field("last_of_cell", 32'(e.last_of_cell), 32'(vtx_if.last_of_cell));
        check_field("overflow", 32'(e.overflow), 32'(vtx_if.overflow));
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (cell_if.valid && cell_if.ready) || (vtx_if.valid && vtx_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cell_if.valid = 1'b0;
    cell_if.corner_a = '0; cell_if.corner_b = '0;
    cell_if.corner_c = '0; cell_if.corner_d = '0;
    cell_if.cell_x = '0; cell_if.cell_y = '0; cell_if.slice = '0;
    for (int i = 0; i < ROWS; i++) begin
      row_ok[i] = 0;
      row_ix[i] = '0;
    end
    left_ok = 0;
    left_ix = '0;
    vtx_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    idle_en = 1'b1;
    test_raster_grids(2);
    set_regs(9'd0, 1'b0);
    test_noise(8);
    set_regs(9'd256, 1'b1);
    test_noise(6);
    set_regs(9'd511, 1'b0);
    test_noise(6);
    set_regs(9'd1, 1'b1);
    test_noise(8);
    set_regs(9'd255, 1'b0);
    test_raster_grids(2);
    test_output_stall();
    drain();
    set_regs(9'($urandom_range(60, 200)), 1'b1);
    test_raster_grids(2);
    test_noise(10);
    set_regs(ISO_RESET, LERP_RESET);
    idle_en = 1'b0;
    test_raster_grids(2);
    test_noise(10);
    drain();

    $display("Covered all corner cases, iso extremes, midpoint and weighted placement,");
    $display("%0d cells, %0d vertex words (%0d new), output stall and sender pauses.",
             cells_taken, words_seen, new_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/msic_pkg.sv
rtl/core/msic_cell_if.sv
rtl/core/msic_vtx_if.sv
rtl/core/msic_ram.sv
rtl/core/msic_front.sv
rtl/core/msic_back.sv
rtl/core/marching_squares_isoline_cells.sv
tb/sv/marching_squares_isoline_cells_tb.sv
